// File: hw/rtl/two_congruence_crt_solver_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-congruence CRT solver
// Concurrent checks in simulation, empty bodies under synthesis.
// ----------------------------------------------------------------------------
`ifndef TWO_CONGRUENCE_CRT_SOLVER_UNIT_DEFINES_SVH
`define TWO_CONGRUENCE_CRT_SOLVER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent holds -> consequent in the same cycle
`define TCCS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// antecedent holds -> consequent in the next cycle
`define TCCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TCCS_ASSERT_SAME(label, ante, cons, msg)
`define TCCS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: hw/rtl/tccs_pkg.sv
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared types for the CRT solver controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tccs_pkg;

    localparam int FIELD_W = 32;
    localparam int RES_W   = 64;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DSTART,
        ST_DWAIT,
        ST_EUMUL,
        ST_EUUPD,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_MUL4,
        ST_DONE
    } state_t;

    // which division is in flight
    typedef enum logic [3:0] {
        PH_AR,   // a mod m
        PH_BR,   // b mod n
        PH_AN,   // (a mod m) mod n
        PH_EU,   // Euclid step r0 / r1
        PH_RG,   // r / g
        PH_MG,   // m / g
        PH_NG,   // n / g
        PH_SM,   // |s| mod (n / g)
        PH_T     // wide product mod (n / g)
    } phase_t;

    typedef enum logic [2:0] {
        MS_NONE,
        MS_EU,   // q * s1
        MS_RS,   // (r / g) * inverse
        MS_MT,   // m * t
        MS_LCM   // (m / g) * n
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     div_start;
        logic     capture;
        phase_t   phase;
        mul_sel_t mul_sel;
        logic     eu_upd;
        logic     sol_add;
        logic     lcm_take;
        logic     set_nosol;
    } ctrl_t;

    typedef struct packed {
        logic zero_mod;
        logic div_done;
        logic rem_nz;
    } stat_t;

endpackage

// File: hw/rtl/tccs_divider.sv
// ----------------------------------------------------------------------------
// tccs_divider
// Restoring divider, one quotient bit per cycle, W or 2W dividend bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tccs_divider #(
    parameter int W = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           wide,
    input  logic [2*W-1:0] dividend,
    input  logic [W-1:0]   divisor,
    output logic           done,
    output logic [2*W-1:0] quot,
    output logic [W-1:0]   rem
);
    localparam int CW = $clog2(2 * W + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [2*W-1:0] quo_reg, quo_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dvs_reg;
    logic [W:0]    trial;
    logic          ge;

    // one restoring step
    always_comb
    begin
        trial    = {rem_reg, quo_reg[2*W-1]};
        ge       = (trial >= {1'b0, dvs_reg});
        rem_next = ge ? W'(trial - {1'b0, dvs_reg}) : trial[W-1:0];
        quo_next = {quo_reg[2*W-2:0], ge};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= wide ? CW'(2 * W) : CW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= wide ? dividend : {dividend[W-1:0], {W{1'b0}}};
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

// File: hw/rtl/tccs_datapath.sv
// ----------------------------------------------------------------------------
// tccs_datapath
// Operand registers, extended Euclid state, shared multiplier and divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tccs_datapath #(
    parameter int W = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tccs_pkg::ctrl_t        ctrl,
    output tccs_pkg::stat_t        stat,
    input  logic [tccs_pkg::FIELD_W-1:0] residue_a,
    input  logic [tccs_pkg::FIELD_W-1:0] modulus_m,
    input  logic [tccs_pkg::FIELD_W-1:0] residue_b,
    input  logic [tccs_pkg::FIELD_W-1:0] modulus_n,
    output logic [tccs_pkg::RES_W-1:0]   solution,
    output logic [tccs_pkg::RES_W-1:0]   combined_modulus,
    output logic                   no_solution
);
    import tccs_pkg::*;

    localparam int SW = W + 2;

    logic [W-1:0] a_reg, m_reg, b_reg, n_reg;
    logic [W-1:0] ar_reg, br_reg, r_reg;
    logic [W-1:0] r0_reg, r1_reg;
    logic signed [SW-1:0] s0_reg, s1_reg;
    logic [W-1:0] rg_reg, mg_reg, ng_reg, sinv_reg, t_reg;
    logic signed [2*SW-1:0] prod_reg;
    logic [2*W-1:0] sol_reg, lcm_reg;
    logic nosol_reg;

    logic           div_done;
    logic [2*W-1:0] div_quot;
    logic [W-1:0]   div_rem;
    logic [2*W-1:0] div_dvd;
    logic [W-1:0]   div_dvs;
    logic           div_wide;

    logic signed [SW-1:0] mul_x, mul_y;
    logic [W:0]   rsum, rnext;
    logic [W-1:0] s_abs, sinv_next;
    logic signed [SW-1:0] s_neg_val;

    // divider operand select
    always_comb
    begin
        div_dvd  = '0;
        div_dvs  = n_reg;
        div_wide = 1'b0;
        s_neg_val = -s0_reg;
        s_abs    = s0_reg[SW-1] ? s_neg_val[W-1:0] : s0_reg[W-1:0];
        unique case (ctrl.phase)
            PH_AR: begin div_dvd = (2*W)'(a_reg);  div_dvs = m_reg;  end
            PH_BR: begin div_dvd = (2*W)'(b_reg);  div_dvs = n_reg;  end
            PH_AN: begin div_dvd = (2*W)'(ar_reg); div_dvs = n_reg;  end
            PH_EU: begin div_dvd = (2*W)'(r0_reg); div_dvs = r1_reg; end
            PH_RG: begin div_dvd = (2*W)'(r_reg);  div_dvs = r0_reg; end
            PH_MG: begin div_dvd = (2*W)'(m_reg);  div_dvs = r0_reg; end
            PH_NG: begin div_dvd = (2*W)'(n_reg);  div_dvs = r0_reg; end
            PH_SM: begin div_dvd = (2*W)'(s_abs);  div_dvs = ng_reg; end
            PH_T:
            begin
                div_dvd  = prod_reg[2*W-1:0];
                div_dvs  = ng_reg;
                div_wide = 1'b1;
            end
            default: begin div_dvd = '0; div_dvs = n_reg; end
        endcase
    end

    tccs_divider #(.W(W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.div_start),
        .wide     (div_wide),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // multiplier operand select
    always_comb
    begin
        mul_x = '0;
        mul_y = '0;
        unique case (ctrl.mul_sel)
            MS_EU:  begin mul_x = SW'(div_quot[W-1:0]); mul_y = s1_reg;          end
            MS_RS:  begin mul_x = SW'(rg_reg);          mul_y = SW'(sinv_reg);   end
            MS_MT:  begin mul_x = SW'(m_reg);           mul_y = SW'(t_reg);      end
            MS_LCM: begin mul_x = SW'(mg_reg);          mul_y = SW'(n_reg);      end
            default: begin mul_x = '0; mul_y = '0; end
        endcase
    end

    // (b - a) mod n and inverse reduction
    always_comb
    begin
        rsum  = {1'b0, br_reg} + {1'b0, n_reg} - {1'b0, div_rem};
        rnext = (rsum >= {1'b0, n_reg}) ? rsum - {1'b0, n_reg} : rsum;
        sinv_next = (s0_reg[SW-1] && (div_rem != '0)) ? ng_reg - div_rem : div_rem;
    end

    // input capture and working registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            a_reg <= residue_a[W-1:0];
            m_reg <= modulus_m[W-1:0];
            b_reg <= residue_b[W-1:0];
            n_reg <= modulus_n[W-1:0];
        end
        if (ctrl.capture)
        begin
            unique case (ctrl.phase)
                PH_AR: ar_reg <= div_rem;
                PH_BR: br_reg <= div_rem;
                PH_AN:
                begin
                    r_reg  <= rnext[W-1:0];
                    r0_reg <= m_reg;
                    r1_reg <= n_reg;
                    s0_reg <= SW'(1);
                    s1_reg <= '0;
                end
                PH_RG: rg_reg   <= div_quot[W-1:0];
                PH_MG: mg_reg   <= div_quot[W-1:0];
                PH_NG: ng_reg   <= div_quot[W-1:0];
                PH_SM: sinv_reg <= sinv_next;
                PH_T:  t_reg    <= div_rem;
                default: ;
            endcase
        end
        if (ctrl.mul_sel != MS_NONE)
            prod_reg <= mul_x * mul_y;
        // Euclid step: shift remainders and Bezout coefficients
        if (ctrl.eu_upd)
        begin
            r0_reg <= r1_reg;
            r1_reg <= div_rem;
            s0_reg <= s1_reg;
            s1_reg <= s0_reg - prod_reg[SW-1:0];
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (ctrl.set_nosol)
        begin
            sol_reg   <= '0;
            lcm_reg   <= '0;
            nosol_reg <= 1'b1;
        end
        else
        begin
            if (ctrl.sol_add)
                sol_reg <= prod_reg[2*W-1:0] + (2*W)'(ar_reg);
            if (ctrl.lcm_take)
            begin
                lcm_reg   <= prod_reg[2*W-1:0];
                nosol_reg <= 1'b0;
            end
        end
    end

    assign stat.zero_mod = (m_reg == '0) || (n_reg == '0);
    assign stat.div_done = div_done;
    assign stat.rem_nz   = (div_rem != '0);

    assign solution         = RES_W'(sol_reg);
    assign combined_modulus = RES_W'(lcm_reg);
    assign no_solution      = nosol_reg;

endmodule

// File: hw/rtl/tccs_ctrl.sv
// ----------------------------------------------------------------------------
// tccs_ctrl
// Sequencer: reductions, Euclid loop, inverse, final products, handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tccs_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  tccs_pkg::stat_t stat,
    output tccs_pkg::ctrl_t ctrl
);
    import tccs_pkg::*;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_AR;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        ctrl       = '0;
        ctrl.phase = phase_reg;
        ctrl.mul_sel = MS_NONE;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.zero_mod)
                begin
                    ctrl.set_nosol = 1'b1;
                    state_next     = ST_DONE;
                end
                else
                begin
                    phase_next = PH_AR;
                    state_next = ST_DSTART;
                end
            end
            ST_DSTART:
            begin
                ctrl.div_start = 1'b1;
                state_next     = ST_DWAIT;
            end
            ST_DWAIT:
            begin
                if (stat.div_done)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = ST_DSTART;
                    unique case (phase_reg)
                        PH_AR: phase_next = PH_BR;
                        PH_BR: phase_next = PH_AN;
                        PH_AN: phase_next = PH_EU;
                        PH_EU: state_next = ST_EUMUL;
                        PH_RG:
                        begin
                            if (stat.rem_nz)
                            begin
                                ctrl.set_nosol = 1'b1;
                                state_next     = ST_DONE;
                            end
                            else
                                phase_next = PH_MG;
                        end
                        PH_MG: phase_next = PH_NG;
                        PH_NG: phase_next = PH_SM;
                        PH_SM: state_next = ST_MUL1;
                        PH_T:  state_next = ST_MUL2;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_EUMUL:
            begin
                ctrl.mul_sel = MS_EU;
                state_next   = ST_EUUPD;
            end
            ST_EUUPD:
            begin
                // remainder zero: r0 now holds the gcd
                ctrl.eu_upd = 1'b1;
                phase_next  = stat.rem_nz ? PH_EU : PH_RG;
                state_next  = ST_DSTART;
            end
            ST_MUL1:
            begin
                ctrl.mul_sel = MS_RS;
                phase_next   = PH_T;
                state_next   = ST_DSTART;
            end
            ST_MUL2:
            begin
                ctrl.mul_sel = MS_MT;
                state_next   = ST_MUL3;
            end
            ST_MUL3:
            begin
                ctrl.mul_sel = MS_LCM;
                ctrl.sol_add = 1'b1;
                state_next   = ST_MUL4;
            end
            ST_MUL4:
            begin
                ctrl.lcm_take = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// File: hw/rtl/two_congruence_crt_solver_unit.sv
// ----------------------------------------------------------------------------
// two_congruence_crt_solver_unit
// Solves x = a mod m, x = b mod n for any nonzero moduli (generalized CRT).
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in      | input     | in_valid / in_ready  | residue_a modulus_m residue_b
//          |           |                      | modulus_n
//  out     | output    | out_valid / out_ready| solution combined_modulus
//          |           |                      | no_solution
//
//  One item at a time. Every division is done by a shared restoring divider,
//  one bit per cycle, so an item's run time grows with k, the number of
//  Euclid steps (up to about 47 at 32 bits).
//  A zero modulus or a failed divisibility test ends the item early.
//  Reset is asynchronous and needs no clearing pass; the result beat is held
//  in registers until out_ready, and in_ready stays low meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "two_congruence_crt_solver_unit_defines.svh"

module two_congruence_crt_solver_unit #(
    parameter int MOD_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] residue_a,
    input  logic [31:0] modulus_m,
    input  logic [31:0] residue_b,
    input  logic [31:0] modulus_n,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] solution,
    output logic [63:0] combined_modulus,
    output logic        no_solution
);
    import tccs_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    tccs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    tccs_datapath #(.W(MOD_WIDTH)) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctrl             (ctrl),
        .stat             (stat),
        .residue_a        (residue_a),
        .modulus_m        (modulus_m),
        .residue_b        (residue_b),
        .modulus_n        (modulus_n),
        .solution         (solution),
        .combined_modulus (combined_modulus),
        .no_solution      (no_solution)
    );

    // checks
    `TCCS_ASSERT_SAME(a_ready_excl, in_ready, !out_valid, "input taken while result pending")
    `TCCS_ASSERT_SAME(a_sol_range, out_valid && !no_solution, solution < combined_modulus, "solution not below lcm")
    `TCCS_ASSERT_SAME(a_nosol_zero, out_valid && no_solution, (solution == 64'd0) && (combined_modulus == 64'd0), "unsolvable beat not zeroed")
    `TCCS_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready, "second item accepted while busy")

endmodule

// File: tb/two_congruence_crt_solver_unit_checker.sv
// ----------------------------------------------------------------------------
// CRT solver result checker
// Watches the input and result channels, predicts each result with exact
// 64-bit arithmetic and compares it field by field with what the block gives.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_congruence_crt_solver_unit_checker #(
    parameter int MOD_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [31:0] residue_a,
    input  logic [31:0] modulus_m,
    input  logic [31:0] residue_b,
    input  logic [31:0] modulus_n,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [63:0] solution,
    input  logic [63:0] combined_modulus,
    input  logic        no_solution,
    output int          fail_count,
    output int          pending_count,
    output int          result_count,
    output int          unsolvable_count
);

    typedef struct packed {
        logic [63:0] x;
        logic [63:0] lcm;
        logic        none;
    } crt_answer_t;

    crt_answer_t answers_due[$];

    // modular inverse of v mod md by extended Euclid, signed 64-bit
    function automatic longint unsigned mod_inverse(longint unsigned v, longint unsigned md);
        longint r0, r1, s0, s1, q, tr, ts;
        r0 = longint'(v % md);
        r1 = longint'(md);
        s0 = 1;
        s1 = 0;
        while (r1 != 0) begin
            q  = r0 / r1;
            tr = r0 - q * r1;
            ts = s0 - q * s1;
            r0 = r1; r1 = tr;
            s0 = s1; s1 = ts;
        end
        s0 = s0 % longint'(md);
        if (s0 < 0)
            s0 = s0 + longint'(md);
        return unsigned'(s0);
    endfunction

    function automatic crt_answer_t solve_pair(logic [31:0] ia, logic [31:0] im,
                                               logic [31:0] ib, logic [31:0] in_n);
        longint unsigned msk, a, m, b, n, g, p, q, tmp, ar, br, r, mg, ng, t;
        crt_answer_t res;
        msk = (64'd1 << MOD_WIDTH) - 1;
        a = ia & msk; m = im & msk; b = ib & msk; n = in_n & msk;
        res = '{x: 64'd0, lcm: 64'd0, none: 1'b1};
        if (m == 0 || n == 0)
            return res;
        ar = a % m;
        br = b % n;
        r  = (br + n - (ar % n)) % n;
        p = m; q = n;
        while (q != 0) begin
            tmp = p % q; p = q; q = tmp;
        end
        g = p;
        if (r % g != 0)
            return res;
        mg = m / g;
        ng = n / g;
        t  = ((r / g) * mod_inverse(mg, ng)) % ng;
        res.x    = ar + m * t;
        res.lcm  = mg * n;
        res.none = 1'b0;
        return res;
    endfunction

    assign pending_count = answers_due.size();

    always @(posedge clk or negedge rst_n) begin
        crt_answer_t want;
        if (!rst_n) begin
            fail_count       <= 0;
            result_count     <= 0;
            unsolvable_count <= 0;
        end else begin
            // input beat: queue the prediction
            if (in_valid && in_ready)
                answers_due.push_back(solve_pair(residue_a, modulus_m, residue_b, modulus_n));
            // result beat: compare against oldest prediction
            if (out_valid && out_ready) begin
                result_count <= result_count + 1;
                if (no_solution)
                    unsolvable_count <= unsolvable_count + 1;
                if (answers_due.size() == 0) begin
                    $error("result beat with no item outstanding");
                    fail_count <= fail_count + 1;
                end else begin
                    want = answers_due.pop_front();
                    if (solution !== want.x || combined_modulus !== want.lcm
                        || no_solution !== want.none) begin
                        fail_count <= fail_count + 1;
                        if (solution !== want.x)
                            $error("solution: expected %0d, got %0d", want.x, solution);
                        if (combined_modulus !== want.lcm)
                            $error("combined_modulus: expected %0d, got %0d",
                                   want.lcm, combined_modulus);
                        if (no_solution !== want.none)
                            $error("no_solution: expected %0d, got %0d",
                                   want.none, no_solution);
                    end
                end
            end
        end
    end

endmodule

// File: tb/two_congruence_crt_solver_unit_test.sv
// ----------------------------------------------------------------------------
// CRT solver testbench
// Directed corner items then random congruence pairs with random idling on
// both channels and one long result stall; a checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_congruence_crt_solver_unit_test;

    localparam int RANDOM_ITEMS = 1100;
    localparam int CYCLE_LIMIT  = 10000000;
    localparam int DRAIN_CYCLES = 600;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] residue_a;
    logic [31:0] modulus_m;
    logic [31:0] residue_b;
    logic [31:0] modulus_n;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] solution;
    logic [63:0] combined_modulus;
    logic        no_solution;

    int fail_count, pending_count, result_count, unsolvable_count;
    int send_idle_pct, recv_idle_pct;
    int cycle_count;
    bit hold_results;
    int items_sent;

    two_congruence_crt_solver_unit dut (.*);

    two_congruence_crt_solver_unit_checker chk (.*);

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // receiver: random stalls, or a long hold when asked
    initial begin
        out_ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_results)
                out_ready <= 1'b0;
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // one input beat, with a random gap first
    task automatic send_pair(logic [31:0] a, logic [31:0] m, logic [31:0] b, logic [31:0] n);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        residue_a <= a;
        modulus_m <= m;
        residue_b <= b;
        modulus_n <= n;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // random modulus: often a multiple of a shared factor so many systems are solvable
    function automatic logic [31:0] pick_modulus(logic [31:0] f);
        case ($urandom_range(4))
            0: return $urandom_range(1, 16);
            1: return $urandom() | 32'd1;
            2: return f * $urandom_range(1, 4000);
            3: return f * $urandom_range(1, 65535);
            default: return $urandom();
        endcase
    endfunction

    task automatic random_pairs(int count);
        logic [31:0] f, m, n, a, b;
        for (int i = 0; i < count; i++) begin
            f = $urandom_range(1, 60000);
            m = pick_modulus(f);
            n = pick_modulus(f);
            a = ($urandom_range(3) == 0) ? $urandom() : $urandom() % (m == 0 ? 1 : m);
            b = $urandom_range(1) ? $urandom() : a + f * $urandom_range(0, 50);
            send_pair(a, m, b, n);
        end
    endtask

    // drop valid right after the last beat, then wait for every result
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        residue_a = '0; modulus_m = '0; residue_b = '0; modulus_n = '0;
        hold_results = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        items_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, coprime, shared factor, unsolvable, unreduced, zero
        send_pair(32'd0, 32'd1, 32'd0, 32'd1);
        send_pair(32'd2, 32'd3, 32'd3, 32'd5);
        send_pair(32'd4, 32'd6, 32'd2, 32'd8);
        send_pair(32'd1, 32'd6, 32'd2, 32'd4);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_pair(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFB);
        send_pair(32'd100, 32'd7, 32'hFFFF_FFFF, 32'd11);
        send_pair(32'd5, 32'd0, 32'd3, 32'd7);
        send_pair(32'd5, 32'd7, 32'd3, 32'd0);
        send_pair(32'd0, 32'd0, 32'd0, 32'd0);
        send_pair(32'd12345, 32'd1000, 32'd345, 32'd1000);
        send_pair(32'd1, 32'd1000, 32'd2, 32'd1000);
        send_pair(32'hAAAA_AAAA, 32'h8000_0000, 32'h5555_5555, 32'h7FFF_FFFF);
        send_pair(32'd1, 32'hB11924E1, 32'd0, 32'h6D73E55F);
        send_pair(32'd7, 32'd1, 32'h8000_0000, 32'hFFFF_FFFF);
        send_pair(32'd3, 32'h8000_0000, 32'd3, 32'h4000_0000);

        // long result hold so the block backs up and stalls its input
        hold_results = 1'b1;
        fork
            begin
                repeat (2000) @(posedge clk);
                hold_results = 1'b0;
            end
            random_pairs(8);
        join
        drain();

        send_idle_pct = 16; recv_idle_pct = 53;
        random_pairs(RANDOM_ITEMS / 3);
        send_idle_pct = 53; recv_idle_pct = 16;
        random_pairs(RANDOM_ITEMS / 3);
        send_idle_pct = 0; recv_idle_pct = 0;
        random_pairs(RANDOM_ITEMS / 3);
        drain();

        $display("Covered %0d items (%0d results, %0d unsolvable) over three idling mixes",
                 items_sent, result_count, unsolvable_count);
        $display("plus corner moduli, unreduced residues and a long result stall.");
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/tccs_pkg.sv
hw/rtl/tccs_divider.sv
hw/rtl/tccs_datapath.sv
hw/rtl/tccs_ctrl.sv
hw/rtl/two_congruence_crt_solver_unit.sv
tb/two_congruence_crt_solver_unit_checker.sv
tb/two_congruence_crt_solver_unit_test.sv
